[src/spfp_pkg.sv]
// ----------------------------------------------------------------------------
// spfp_pkg: shared types and constants of the stereo frame packer
// Field widths, register indexes, packing mode codes and config record.
// ----------------------------------------------------------------------------
package spfp_pkg;

  localparam int POS_BITS      = 8;
  localparam int PIX_PORT_BITS = 32;
  localparam int MODE_BITS     = 2;
  localparam int DIM_BITS      = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;
  localparam int COORD_BITS    = 9;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QCNT_BITS     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_INTERLEAVED  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_TOP_BOTTOM   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SIDE_BY_SIDE = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 9'd256;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [DIM_BITS-1:0]  width;
    logic [DIM_BITS-1:0]  height;
  } cfg_t;

endpackage

[src/spfp_queue.sv]
// ----------------------------------------------------------------------------
// spfp_queue: two-entry queue
// Registered FIFO that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module spfp_queue
  import spfp_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DW-1:0]        push_data,
  input  logic                 pop,
  output logic                 valid,
  output logic [QCNT_BITS-1:0] count,
  output logic [DW-1:0]        head
);

  logic [DW-1:0]        mem_r [QUEUE_DEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 pop_ok, push_ok;

  assign pop_ok  = pop && (count_r != '0);
  assign push_ok = push && ((count_r != QCNT_BITS'(QUEUE_DEPTH)) || pop_ok);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    count_nxt  = count_r + QCNT_BITS'(push_ok) - QCNT_BITS'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = (count_r != '0);
  assign count = count_r;
  assign head  = mem_r[rd_ptr_r];

endmodule

[src/spfp_front.sv]
// ----------------------------------------------------------------------------
// spfp_front: request decode
// Accepts items, maps read positions to eye and store cell, builds address.
// ----------------------------------------------------------------------------
module spfp_front
  import spfp_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 32,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                     in_valid,
  input  logic                     in_func,
  input  logic [POS_BITS-1:0]      in_pos_x,
  input  logic [POS_BITS-1:0]      in_pos_y,
  input  logic [PIX_PORT_BITS-1:0] in_left_pixel,
  input  logic [PIX_PORT_BITS-1:0] in_right_pixel,
  input  cfg_t                     cfg,
  input  logic                     q_full,
  output logic                     push,
  output logic                     op_is_read,
  output logic                     op_right,
  output logic [AW-1:0]            op_addr,
  output logic [PIXEL_BITS-1:0]    op_left_pix,
  output logic [PIXEL_BITS-1:0]    op_right_pix
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  function automatic logic [COORD_BITS-1:0] wrap(input logic [COORD_BITS-1:0] v,
                                                 input int m);
    logic [COORD_BITS-1:0] r;
    int k;
    r = v;
    for (k = COORD_BITS - 1; k >= 0; k--) begin
      if (((m << k) < (1 << COORD_BITS)) && (int'(r) >= (m << k))) begin
        r = r - COORD_BITS'(m << k);
      end
    end
    return r;
  endfunction

  logic [DIM_BITS-1:0]   w_clamp, h_clamp;
  logic [DIM_BITS:0]     w_inc, h_inc;
  logic [DIM_BITS-1:0]   half_w, half_h;
  logic [POS_BITS-1:0]   x_off, y_off;
  logic [COORD_BITS-1:0] col, row;
  logic                  right;
  logic [CW-1:0]         col_idx;
  logic [RW-1:0]         row_idx;

  always_comb begin
    if (cfg.width == '0) begin
      w_clamp = DIM_BITS'(1);
    end else if (int'(cfg.width) > MAX_WIDTH) begin
      w_clamp = DIM_BITS'(MAX_WIDTH);
    end else begin
      w_clamp = cfg.width;
    end
    if (cfg.height == '0) begin
      h_clamp = DIM_BITS'(1);
    end else if (int'(cfg.height) > MAX_HEIGHT) begin
      h_clamp = DIM_BITS'(MAX_HEIGHT);
    end else begin
      h_clamp = cfg.height;
    end
    w_inc  = {1'b0, w_clamp} + (DIM_BITS + 1)'(1);
    h_inc  = {1'b0, h_clamp} + (DIM_BITS + 1)'(1);
    half_w = w_inc[DIM_BITS:1];
    half_h = h_inc[DIM_BITS:1];
    x_off  = in_pos_x - half_w[POS_BITS-1:0];
    y_off  = in_pos_y - half_h[POS_BITS-1:0];
  end

  always_comb begin
    col   = {1'b0, in_pos_x};
    row   = {1'b0, in_pos_y};
    right = 1'b0;
    if (in_func == FUNC_READ) begin
      case (cfg.mode)
        MODE_TOP_BOTTOM: begin
          if ({1'b0, in_pos_y} < half_h) begin
            row = {in_pos_y, 1'b0};
          end else begin
            row   = {y_off, 1'b1};
            right = 1'b1;
          end
        end
        MODE_SIDE_BY_SIDE: begin
          if ({1'b0, in_pos_x} < half_w) begin
            col = {in_pos_x, 1'b0};
          end else begin
            col   = {x_off, 1'b1};
            right = 1'b1;
          end
        end
        default: begin
          right = in_pos_y[0];
        end
      endcase
    end
  end

  assign col_idx = CW'(wrap(col, MAX_WIDTH));
  assign row_idx = RW'(wrap(row, MAX_HEIGHT));

  assign push         = in_valid && !q_full;
  assign op_is_read   = (in_func == FUNC_READ);
  assign op_right     = right;
  assign op_addr      = AW'(row_idx) * AW'(MAX_WIDTH) + AW'(col_idx);
  assign op_left_pix  = in_left_pixel[PIXEL_BITS-1:0];
  assign op_right_pix = in_right_pixel[PIXEL_BITS-1:0];

endmodule

[src/spfp_back.sv]
// ----------------------------------------------------------------------------
// spfp_back: pixel stores and result buffer
// Executes queued writes and reads, buffers read results for the consumer.
// ----------------------------------------------------------------------------
module spfp_back
  import spfp_pkg::*;
#(
  parameter int DEPTH      = 65536,
  parameter int PIXEL_BITS = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic                  q_is_read,
  input  logic                  q_right,
  input  logic [AW-1:0]         q_addr,
  input  logic [PIXEL_BITS-1:0] q_left_pix,
  input  logic [PIXEL_BITS-1:0] q_right_pix,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_pix,
  output logic                  out_right
);

  logic [PIXEL_BITS-1:0] left_mem  [DEPTH];
  logic [PIXEL_BITS-1:0] right_mem [DEPTH];

  logic [PIXEL_BITS-1:0] rd_left_r, rd_right_r;
  logic                  rd_sel_r;
  logic                  rd_valid_r, rd_valid_nxt;
  logic                  issue_rd, issue_wr, room, opop;
  logic [QCNT_BITS-1:0]  ocount;
  logic [PIXEL_BITS:0]   obuf_in, obuf_head;

  assign opop     = out_valid && !out_stall;
  assign room     = ((QCNT_BITS + 1)'(ocount) + (QCNT_BITS + 1)'(rd_valid_r)) <
                    ((QCNT_BITS + 1)'(QUEUE_DEPTH) + (QCNT_BITS + 1)'(opop));
  assign q_pop    = q_valid && (!q_is_read || room);
  assign issue_rd = q_pop && q_is_read;
  assign issue_wr = q_pop && !q_is_read;

  assign rd_valid_nxt = issue_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_wr) begin
      left_mem[q_addr]  <= q_left_pix;
      right_mem[q_addr] <= q_right_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_rd) begin
      rd_left_r  <= left_mem[q_addr];
      rd_right_r <= right_mem[q_addr];
      rd_sel_r   <= q_right;
    end
  end

  assign obuf_in = {rd_sel_r, (rd_sel_r ? rd_right_r : rd_left_r)};

  spfp_queue #(
    .DW (PIXEL_BITS + 1)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_valid_r),
    .push_data (obuf_in),
    .pop       (opop),
    .valid     (out_valid),
    .count     (ocount),
    .head      (obuf_head)
  );

  assign out_pix   = obuf_head[PIXEL_BITS-1:0];
  assign out_right = obuf_head[PIXEL_BITS];

endmodule

[src/stereo_passive_frame_packer_unit.sv]
// Reads pass the request queue, the store read registers and the result buffer; output stall delays them.
// Writes produce no result and land in the store when they leave the request queue.
// Throughput: one beat per cycle while in_stall is low, set by one store port access per beat.
// Reset: synchronous, active low; clears queues and config (mode 0, 256 x 256).
// Pixel stores are not cleared by reset.
// ----------------------------------------------------------------------------
// stereo_passive_frame_packer_unit: stereo frame packer top level
// Config registers, decode front, request queue and store back end.
// ----------------------------------------------------------------------------
module stereo_passive_frame_packer_unit
  import spfp_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [POS_BITS-1:0]      in_pos_x,
  input  logic [POS_BITS-1:0]      in_pos_y,
  input  logic [PIX_PORT_BITS-1:0] in_left_pixel,
  input  logic [PIX_PORT_BITS-1:0] in_right_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIX_PORT_BITS-1:0] out_packed_pixel,
  output logic                     out_from_right_eye,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = 2 + AW + 2 * PIXEL_BITS;

  cfg_t cfg_r, cfg_nxt;

  logic                  push, q_valid, q_pop;
  logic [QCNT_BITS-1:0]  q_count;
  logic                  op_is_read, op_right;
  logic [AW-1:0]         op_addr;
  logic [PIXEL_BITS-1:0] op_left_pix, op_right_pix;
  logic [QW-1:0]         q_in, q_head;
  logic [PIXEL_BITS-1:0] out_pix;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   cfg_nxt.mode   = cfg_wdata[MODE_BITS-1:0];
        REG_WIDTH:  cfg_nxt.width  = cfg_wdata[DIM_BITS-1:0];
        REG_HEIGHT: cfg_nxt.height = cfg_wdata[DIM_BITS-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_INTERLEAVED;
      cfg_r.width  <= DIM_RESET;
      cfg_r.height <= DIM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = (q_count == QCNT_BITS'(QUEUE_DEPTH));

  spfp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_func        (in_func),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_left_pixel  (in_left_pixel),
    .in_right_pixel (in_right_pixel),
    .cfg            (cfg_r),
    .q_full         (in_stall),
    .push           (push),
    .op_is_read     (op_is_read),
    .op_right       (op_right),
    .op_addr        (op_addr),
    .op_left_pix    (op_left_pix),
    .op_right_pix   (op_right_pix)
  );

  assign q_in = {op_is_read, op_right, op_addr, op_left_pix, op_right_pix};

  spfp_queue #(
    .DW (QW)
  ) u_req_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .pop       (q_pop),
    .valid     (q_valid),
    .count     (q_count),
    .head      (q_head)
  );

  spfp_back #(
    .DEPTH      (DEPTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_is_read   (q_head[QW-1]),
    .q_right     (q_head[QW-2]),
    .q_addr      (q_head[2*PIXEL_BITS +: AW]),
    .q_left_pix  (q_head[PIXEL_BITS +: PIXEL_BITS]),
    .q_right_pix (q_head[PIXEL_BITS-1:0]),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pix     (out_pix),
    .out_right   (out_from_right_eye)
  );

  assign out_packed_pixel = PIX_PORT_BITS'(out_pix);

endmodule

[src/spfp_chk.sv]
// ----------------------------------------------------------------------------
// spfp_chk: port checker for the stereo frame packer
// Watches reset behavior, result timing and the result handshake.
// ----------------------------------------------------------------------------
module spfp_chk
  import spfp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [PIX_PORT_BITS-1:0] out_packed_pixel,
  input logic                     out_from_right_eye
);

  a_rst_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in_open: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_min_latency: assert property (@(posedge clk)
    (out_valid && !$past(out_valid)) |-> $past(rst_n, 3))
    else $error("result appeared faster than the read path allows");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_packed_pixel) && $stable(out_from_right_eye)))
    else $error("stalled result beat changed or dropped");

endmodule

bind stereo_passive_frame_packer_unit spfp_chk u_spfp_chk (.*);

[verif/tb_stereo_passive_frame_packer_unit.sv]
// ----------------------------------------------------------------------------
// tb_stereo_passive_frame_packer_unit: self-checking bench of the frame packer
// Loads left and right eye pixel pairs, reads packed pixels in every packing
// mode and random frame sizes, and checks each result against an in-bench copy
// of both eye frames, with random source gaps and sink stalls on both sides.
// ----------------------------------------------------------------------------
module tb_stereo_passive_frame_packer_unit;
  import spfp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TOTAL_BEATS  = 1350;
  localparam int STORE_COLS   = 256;
  localparam int STORE_ROWS   = 256;
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_PORT_BITS-1:0] pixel;
    logic                     right_eye;
  } packed_beat_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_func;
  logic [POS_BITS-1:0]      in_pos_x;
  logic [POS_BITS-1:0]      in_pos_y;
  logic [PIX_PORT_BITS-1:0] in_left_pixel;
  logic [PIX_PORT_BITS-1:0] in_right_pixel;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [PIX_PORT_BITS-1:0] out_packed_pixel;
  logic                     out_from_right_eye;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  logic [MODE_BITS-1:0]     mode_reg;
  logic [DIM_BITS-1:0]      width_reg;
  logic [DIM_BITS-1:0]      height_reg;
  logic [PIX_PORT_BITS-1:0] left_frame [int];
  logic [PIX_PORT_BITS-1:0] right_frame [int];
  packed_beat_t             pending_pixels [$];

  int          errors;
  int          beats_sent;
  bit          send_steady;
  bit          drain_steady;
  int unsigned stall_left = 0;

  stereo_passive_frame_packer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_left_pixel     (in_left_pixel),
    .in_right_pixel    (in_right_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packed_pixel  (out_packed_pixel),
    .out_from_right_eye(out_from_right_eye),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int clamp_dim(input logic [DIM_BITS-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Map an output position to the eye and store entry it is packed from.
  function automatic void locate_source(input logic [POS_BITS-1:0] x,
                                        input logic [POS_BITS-1:0] y,
                                        output int entry, output logic right);
    int col, row, half;
    col = int'(x);
    row = int'(y);
    right = 1'b0;
    case (mode_reg)
      MODE_TOP_BOTTOM: begin
        half = (clamp_dim(height_reg, STORE_ROWS) + 1) / 2;
        if (y < half) row = 2 * y;
        else begin
          row = 2 * (y - half) + 1;
          right = 1'b1;
        end
      end
      MODE_SIDE_BY_SIDE: begin
        half = (clamp_dim(width_reg, STORE_COLS) + 1) / 2;
        if (x < half) col = 2 * x;
        else begin
          col = 2 * (x - half) + 1;
          right = 1'b1;
        end
      end
      default: right = y[0];
    endcase
    entry = (row % STORE_ROWS) * STORE_COLS + (col % STORE_COLS);
  endfunction

  function automatic int unsigned draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_beat(input logic func, input logic [POS_BITS-1:0] x,
                           input logic [POS_BITS-1:0] y,
                           input logic [PIX_PORT_BITS-1:0] lp,
                           input logic [PIX_PORT_BITS-1:0] rp);
    int unsigned  gap;
    int           entry;
    logic         right;
    packed_beat_t want;
    gap = draw_wait(send_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_left_pixel  <= lp;
    in_right_pixel <= rp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    beats_sent++;
    if (func == FUNC_WRITE) begin
      entry = int'({y, x});
      left_frame[entry]  = lp;
      right_frame[entry] = rp;
    end else begin
      locate_source(x, y, entry, right);
      want.pixel     = right ? right_frame[entry] : left_frame[entry];
      want.right_eye = right;
      pending_pixels.push_back(want);
    end
  endtask

  // Load the source entry first when it has never been written.
  task automatic read_pixel(input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y);
    int   entry;
    logic right;
    locate_source(x, y, entry, right);
    if (!left_frame.exists(entry))
      send_beat(FUNC_WRITE, entry[7:0], entry[15:8], $urandom, $urandom);
    send_beat(FUNC_READ, x, y, $urandom, $urandom);
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [MODE_BITS-1:0] mode,
                              input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
    logic [CFG_DATA_BITS-MODE_BITS-1:0] pad;
    settle;
    pad = (CFG_DATA_BITS-MODE_BITS)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_wdata <= {pad, mode};
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mode_reg   = mode;
    width_reg  = w;
    height_reg = h;
  endtask

  function automatic logic [DIM_BITS-1:0] random_dim;
    logic [DIM_BITS-1:0] corners [7];
    corners = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 6)];
    return DIM_BITS'($urandom_range(1, 256));
  endfunction

  task automatic test_interleaved_reset_config;
    send_beat(FUNC_WRITE, 8'd0, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(FUNC_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(FUNC_WRITE, 8'd170, 8'd85, 32'hAAAA_AAAA, 32'h5555_5555);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
    read_pixel(8'd170, 8'd85);
    send_beat(FUNC_WRITE, 8'd3, 8'd4, 32'h1234_5678, 32'h9ABC_DEF0);
    read_pixel(8'd3, 8'd4);
  endtask

  task automatic test_top_bottom;
    write_config(MODE_TOP_BOTTOM, 9'd256, 9'd256);
    read_pixel(8'd9, 8'd127);
    read_pixel(8'd9, 8'd128);
    write_config(MODE_TOP_BOTTOM, 9'd5, 9'd5);
    read_pixel(8'd1, 8'd2);
    read_pixel(8'd1, 8'd3);
    read_pixel(8'd7, 8'd200);
  endtask

  task automatic test_side_by_side;
    write_config(MODE_SIDE_BY_SIDE, 9'd1, 9'd7);
    read_pixel(8'd0, 8'd6);
    read_pixel(8'd255, 8'd6);
    write_config(MODE_SIDE_BY_SIDE, 9'd256, 9'd256);
    read_pixel(8'd127, 8'd0);
    read_pixel(8'd128, 8'd0);
  endtask

  task automatic test_spare_mode_and_clamp;
    write_config(MODE_SPARE, 9'd0, 9'd511);
    read_pixel(8'd2, 8'd1);
    write_config(MODE_TOP_BOTTOM, 9'd511, 9'd0);
    read_pixel(8'd0, 8'd1);
    write_config(MODE_SIDE_BY_SIDE, 9'd511, 9'd0);
    read_pixel(8'd200, 8'd3);
  endtask

  task automatic test_random_traffic;
    int                  phase;
    logic [POS_BITS-1:0] x, y;
    phase = 0;
    while (beats_sent < TOTAL_BEATS) begin
      case (phase)
        0:       write_config(MODE_TOP_BOTTOM, 9'd1, 9'd1);
        1:       write_config(MODE_SIDE_BY_SIDE, 9'd256, 9'd256);
        2:       write_config(MODE_INTERLEAVED, 9'd1, 9'd256);
        default: write_config(MODE_BITS'($urandom_range(0, 3)), random_dim(), random_dim());
      endcase
      repeat (4) begin
        send_steady  = ($urandom_range(0, 3) == 0);
        drain_steady = ($urandom_range(0, 3) == 0);
        repeat (40) begin
          if (beats_sent < TOTAL_BEATS) begin
            if ($urandom_range(0, 1)) begin
              x = POS_BITS'($urandom_range(0, 7));
              y = POS_BITS'($urandom_range(0, 7));
            end else begin
              x = POS_BITS'($urandom);
              y = POS_BITS'($urandom);
            end
            if ($urandom_range(0, 9) < 4) send_beat(FUNC_WRITE, x, y, $urandom, $urandom);
            else read_pixel(x, y);
          end
        end
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      stall_left = draw_wait(drain_steady);
      out_stall <= (stall_left != 0);
    end else if (rst_n && out_valid && stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin : result_check
    packed_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result beat: packed_pixel %h", out_packed_pixel);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_packed_pixel !== want.pixel) begin
          $error("packed_pixel: expected %h, got %h", want.pixel, out_packed_pixel);
          errors++;
        end
        if (out_from_right_eye !== want.right_eye) begin
          $error("from_right_eye: expected %b, got %b", want.right_eye, out_from_right_eye);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_valid       = 1'b0;
    in_func        = FUNC_WRITE;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_left_pixel  = '0;
    in_right_pixel = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_MODE;
    cfg_wdata      = '0;
    errors         = 0;
    beats_sent     = 0;
    send_steady    = 1'b0;
    drain_steady   = 1'b0;
    mode_reg       = MODE_INTERLEAVED;
    width_reg      = DIM_RESET;
    height_reg     = DIM_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_interleaved_reset_config;
    test_top_bottom;
    test_side_by_side;
    test_spare_mode_and_clamp;
    test_random_traffic;
    settle;
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
src/spfp_pkg.sv
src/spfp_queue.sv
src/spfp_front.sv
src/spfp_back.sv
src/stereo_passive_frame_packer_unit.sv
src/spfp_chk.sv
verif/tb_stereo_passive_frame_packer_unit.sv
